[src/ddo_pkg.sv]
// shared types, constants and tables for the differential drive odometry block
`timescale 1ns / 1ps
package ddo_pkg;

    localparam int CordicIterations = 24;
    localparam int IterW = $clog2(CordicIterations + 1);

    localparam logic [31:0] CordicGain = 32'h26DD3B6A;

    localparam logic [1:0] RegDistPerCount = 2'd0;
    localparam logic [1:0] RegAnglePerCount = 2'd1;
    localparam logic [1:0] RegVelocityScale = 2'd2;
    localparam logic [1:0] RegInvWheelBase = 2'd3;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [15:0] left_rate;
        logic signed [15:0] right_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
        logic [31:0]        heading;
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

endpackage

[src/ddo_if.sv]
// valid/ready channel interfaces for items and configuration writes
`timescale 1ns / 1ps
interface ddo_in_if import ddo_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/diff_drive_odometry.sv]
// differential drive wheel odometry top level
`timescale 1ns / 1ps
// Takes one request of encoder counts and motor speeds and returns one pose and
// velocity result. One shared 33x33 signed multiplier is used in turn for the
// distance, heading change, both rotation products and the velocities, and one
// shift/add CORDIC stage runs once per iteration. Input is held off until the
// result has been taken from the output register.
module diff_drive_odometry import ddo_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ddo_in_if.sink      in_ch,
    ddo_out_if.source   out_ch,
    ddo_cfg_if.sink     cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MUL_D, S_MUL_T, S_CORDIC, S_MUL_C, S_MUL_S,
        S_MUL_L, S_MUL_V, S_MUL_W, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic [23:0] dpc_reg, vsc_reg, iwb_reg;
    logic [31:0] apc_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [31:0] head_reg, prev_l_reg, prev_r_reg;
    in_item_t item_reg;
    logic signed [32:0] dl_reg, dr_reg;
    logic signed [31:0] d_reg;
    logic signed [32:0] dv_reg;
    logic [31:0] dth_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic flip_reg;
    logic [IterW-1:0] it_reg;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic [4:0] it5;
    logic signed [33:0] xs, ys;
    out_item_t res_reg;
    logic out_v_reg;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = out_v_reg;
    assign out_ch.data = res_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_MUL_D: begin ma = dl_reg + dr_reg; mb = {9'd0, dpc_reg}; end
            S_MUL_T: begin ma = dr_reg - dl_reg; mb = {1'b0, apc_reg}; end
            S_MUL_C: begin ma = 33'(d_reg); mb = flip_reg ? -cx_reg[32:0] : cx_reg[32:0]; end
            S_MUL_S: begin ma = 33'(d_reg); mb = flip_reg ? -cy_reg[32:0] : cy_reg[32:0]; end
            S_MUL_L: begin
                ma = 33'(item_reg.left_rate) + 33'(item_reg.right_rate);
                mb = {9'd0, vsc_reg};
            end
            S_MUL_V: begin
                ma = 33'(item_reg.right_rate) - 33'(item_reg.left_rate);
                mb = {9'd0, vsc_reg};
            end
            S_MUL_W: begin ma = dv_reg; mb = {9'd0, iwb_reg}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    assign prod = 66'(ma) * 66'(mb);
    assign it5 = 5'(it_reg);
    assign xs = cx_reg >>> it_reg;
    assign ys = cy_reg >>> it_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dpc_reg <= 24'd5270718;
            apc_reg <= 32'd715827883;
            vsc_reg <= 24'd838861;
            iwb_reg <= 24'd218453;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            head_reg <= '0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    8'(RegDistPerCount):  dpc_reg <= cfg.data.data[23:0];
                    8'(RegAnglePerCount): apc_reg <= cfg.data.data;
                    8'(RegVelocityScale): vsc_reg <= cfg.data.data[23:0];
                    8'(RegInvWheelBase):  iwb_reg <= cfg.data.data[23:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: if (in_ch.valid)
                begin
                    item_reg <= in_ch.data;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    dl_reg <= 33'(signed'(item_reg.left_count - prev_l_reg));
                    dr_reg <= 33'(signed'(item_reg.right_count - prev_r_reg));
                    prev_l_reg <= item_reg.left_count;
                    prev_r_reg <= item_reg.right_count;
                    // fold into the half turn round zero
                    flip_reg <= head_reg[31] ^ head_reg[30];
                    cz_reg <= 34'(signed'(head_reg + ((head_reg[31] ^ head_reg[30])
                        ? 32'h80000000 : 32'h0)));
                    cx_reg <= 34'(CordicGain);
                    cy_reg <= '0;
                    it_reg <= '0;
                    state_reg <= S_MUL_D;
                end
                S_MUL_D: begin
                    d_reg <= sat32(64'(prod >>> 9));
                    state_reg <= S_MUL_T;
                end
                S_MUL_T: begin
                    dth_reg <= prod[31:0];
                    state_reg <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - 34'(atan_turn(it5));
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + 34'(atan_turn(it5));
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IterW'(CordicIterations - 1))
                        state_reg <= S_MUL_C;
                end
                S_MUL_C: begin
                    pos_x_reg <= sat32(64'(pos_x_reg) + 64'(prod >>> 30));
                    state_reg <= S_MUL_S;
                end
                S_MUL_S: begin
                    pos_y_reg <= sat32(64'(pos_y_reg) + 64'(prod >>> 30));
                    head_reg <= head_reg + dth_reg;
                    state_reg <= S_MUL_L;
                end
                S_MUL_L: begin
                    res_reg.linear_velocity <= sat32(64'(prod >>> 9));
                    state_reg <= S_MUL_V;
                end
                S_MUL_V: begin
                    // fits in 33 bits: 17 + 24 - 8
                    dv_reg <= 33'(prod >>> 8);
                    state_reg <= S_MUL_W;
                end
                S_MUL_W: begin
                    res_reg.angular_velocity <= sat32(64'(prod >>> 16));
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    res_reg.x_position <= pos_x_reg;
                    res_reg.y_position <= pos_y_reg;
                    res_reg.heading <= head_reg;
                    out_v_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (out_ch.ready)
                begin
                    out_v_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[src/ddo_checker.sv]
// port level checks for the odometry block and their bind
`timescale 1ns / 1ps
module ddo_assertions (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [159:0] out_data
);
    // one request in flight: never ready while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready with result pending");
    // accepted request is not answered in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("result dropped or changed");
    // after a result is taken the block returns to ready
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready) else $error("not ready after result");
endmodule

bind diff_drive_odometry ddo_assertions u_ddo_assertions (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);

[tb/ddo_checker.sv]
// checker: watches the request, result and register channels, predicts and compares
`timescale 1ns / 1ps
module ddo_checker import ddo_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_item_t cfg_data,
    output int        fail_count,
    output int        pending,
    output int        results_seen
);

    logic [23:0] dist_per_count;
    logic [31:0] angle_per_count;
    logic [23:0] vel_scale;
    logic [23:0] inv_base;

    logic signed [31:0] pos_x, pos_y;
    logic [31:0] head_acc, last_left, last_right;

    out_item_t expected_poses[$];

    function automatic longint shr_floor(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // rotation mode cordic giving cos and sin of a binary angle in Q2.30
    task automatic heading_cos_sin(input logic [31:0] ang, output longint c,
                                   output longint s);
        logic [31:0] a;
        longint x, y, z, xs, ys;
        bit flip;
        a = ang;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip)
            a = a + 32'h80000000;
        x = longint'(CordicGain);
        y = 0;
        z = longint'(signed'(a));
        for (int i = 0; i < CordicIterations && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_turn(i[4:0]));
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_turn(i[4:0]));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input in_item_t req);
        longint dl, dr, d, c, s, ls, rs, lin, dv, ang;
        logic [31:0] dtheta;
        logic [31:0] ddl, ddr;
        out_item_t r;
        ddl = req.left_count - last_left;
        ddr = req.right_count - last_right;
        dl = longint'(signed'(ddl));
        dr = longint'(signed'(ddr));
        ls = longint'(req.left_rate);
        rs = longint'(req.right_rate);
        d = clamp32(shr_floor((dl + dr) * longint'(dist_per_count), 9));
        dtheta = 32'(longint'(dr - dl) * longint'(angle_per_count));
        heading_cos_sin(head_acc, c, s);
        pos_x = 32'(clamp32(longint'(pos_x) + shr_floor(d * c, 30)));
        pos_y = 32'(clamp32(longint'(pos_y) + shr_floor(d * s, 30)));
        head_acc = head_acc + dtheta;
        last_left = req.left_count;
        last_right = req.right_count;
        lin = clamp32(shr_floor((ls + rs) * longint'(vel_scale), 9));
        dv = shr_floor((rs - ls) * longint'(vel_scale), 8);
        ang = clamp32(shr_floor(dv * longint'(inv_base), 16));
        r.x_position = pos_x;
        r.y_position = pos_y;
        r.heading = head_acc;
        r.linear_velocity = 32'(lin);
        r.angular_velocity = 32'(ang);
        expected_poses.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] want,
                          input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %h got %h", what, want, got);
    endtask

    task automatic compare_pose(input out_item_t got);
        out_item_t want;
        if (expected_poses.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = expected_poses.pop_front();
        if (got.x_position !== want.x_position)
            report("x_position", want.x_position, got.x_position);
        if (got.y_position !== want.y_position)
            report("y_position", want.y_position, got.y_position);
        if (got.heading !== want.heading)
            report("heading", want.heading, got.heading);
        if (got.linear_velocity !== want.linear_velocity)
            report("linear_velocity", want.linear_velocity, got.linear_velocity);
        if (got.angular_velocity !== want.angular_velocity)
            report("angular_velocity", want.angular_velocity, got.angular_velocity);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_per_count = 24'd5270718;
            angle_per_count = 32'd715827883;
            vel_scale = 24'd838861;
            inv_base = 24'd218453;
            pos_x = '0;
            pos_y = '0;
            head_acc = '0;
            last_left = '0;
            last_right = '0;
            expected_poses.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    8'(RegDistPerCount):   dist_per_count = cfg_data.data[23:0];
                    8'(RegAnglePerCount):  angle_per_count = cfg_data.data;
                    8'(RegVelocityScale):  vel_scale = cfg_data.data[23:0];
                    8'(RegInvWheelBase):   inv_base = cfg_data.data[23:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                compare_pose(out_data);
                results_seen = results_seen + 1;
            end
            if (in_valid && in_ready)
                predict_pose(in_data);
            pending = expected_poses.size();
        end
    end

endmodule

[tb/diff_drive_odometry_tb.sv]
// testbench top: clock, reset, stimulus and verdict for the odometry block
`timescale 1ns / 1ps
module diff_drive_odometry_tb import ddo_pkg::*; ();

    localparam int NumRandom = 1800;
    localparam longint CycleLimit = 64'd2000000;

    logic clk;
    logic rst_n;
    int   fail_count, pending, results_seen;
    longint cycles;
    int   stall_phase;
    int   items_sent;

    ddo_in_if  in_ch();
    ddo_out_if out_ch();
    ddo_cfg_if cfg();

    // running totals so counts move as a real encoder would
    logic [31:0] left_total, right_total;

    diff_drive_odometry DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
    );

    ddo_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_data(cfg.data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver stalls on its own pattern: calm stretches, then choppy ones
    initial
    begin
        out_ch.ready = 1'b0;
        stall_phase = 0;
        forever
        begin
            @(negedge clk);
            stall_phase++;
            if ((stall_phase / 300) % 3 == 0)
                out_ch.ready <= 1'b1;
            else if ((stall_phase / 300) % 3 == 1)
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                out_ch.ready <= ($urandom_range(0, 9) < 3);
        end
    end

    task automatic send_request(input in_item_t req);
        in_ch.data = req;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
        items_sent++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        cfg.data = '{index: idx, data: value};
        cfg.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic drain;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic send_motion(input logic signed [31:0] dl, input logic signed [31:0] dr,
                               input logic [15:0] ls, input logic [15:0] rs);
        in_item_t req;
        left_total = left_total + dl;
        right_total = right_total + dr;
        req.left_count = left_total;
        req.right_count = right_total;
        req.left_rate = ls;
        req.right_rate = rs;
        send_request(req);
    endtask

    function automatic logic signed [31:0] rand_step();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1, 2:    return $signed(32'($urandom_range(0, 2000000))) - 1000000;
            default: return $signed(32'($urandom_range(0, 4000))) - 2000;
        endcase
    endfunction

    task automatic random_phase(input int n);
        int gap;
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
                repeat (gap) @(negedge clk);
            end
            burst--;
            send_motion(rand_step(), rand_step(), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        in_item_t req;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        items_sent = 0;
        left_total = '0;
        right_total = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: first step against zero, extremes, encoder wrap, saturation
        send_motion(0, 0, 16'h0000, 16'h0000);
        send_motion(1000, 1000, 16'h7FFF, 16'h7FFF);
        send_motion(-500, 700, 16'h8000, 16'h8000);
        send_motion(0, 0, 16'h8000, 16'h7FFF);
        send_motion(0, 0, 16'h7FFF, 16'h8000);
        req = '{left_count: 32'sh7FFFFFFF, right_count: 32'sh80000000,
                left_rate: 16'sh1234, right_rate: 16'shEDCB};
        send_request(req);
        req = '{left_count: 32'sh80000000, right_count: 32'sh7FFFFFFF,
                left_rate: 16'sh0001, right_rate: 16'shFFFF};
        send_request(req);
        req = '{left_count: 32'sh00000000, right_count: 32'shFFFFFFFF,
                left_rate: 16'shAAAA, right_rate: 16'sh5555};
        send_request(req);
        req = '{left_count: 32'sh7FFFFFFF, right_count: 32'sh7FFFFFFF,
                left_rate: 16'sh5555, right_rate: 16'shAAAA};
        send_request(req);
        left_total = 32'h7FFFFFFF;
        right_total = 32'h7FFFFFFF;
        for (int i = 0; i < 8; i++)
            send_motion(40000000, 40000000, 16'h4000, 16'h4000);
        for (int i = 0; i < 6; i++)
            send_motion(-3000, 3000, 16'hC000, 16'h4000);
        drain();

        // register extremes, with out of range indices that must be ignored
        write_reg(8'(RegDistPerCount), 32'hFFFFFFFF);
        write_reg(8'(RegAnglePerCount), 32'hFFFFFFFF);
        write_reg(8'(RegVelocityScale), 32'hFFFFFFFF);
        write_reg(8'(RegInvWheelBase), 32'hFFFFFFFF);
        write_reg(8'd4, 32'h0);
        write_reg(8'hFF, 32'h0);
        random_phase(NumRandom / 6);
        drain();

        write_reg(8'(RegDistPerCount), 32'h0);
        write_reg(8'(RegAnglePerCount), 32'h0);
        write_reg(8'(RegVelocityScale), 32'h0);
        write_reg(8'(RegInvWheelBase), 32'h0);
        random_phase(NumRandom / 12);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            write_reg(8'(RegDistPerCount), $urandom);
            write_reg(8'(RegAnglePerCount), $urandom);
            write_reg(8'(RegVelocityScale), $urandom);
            write_reg(8'(RegInvWheelBase), $urandom);
            random_phase(NumRandom / 6);
            drain();
        end

        write_reg(8'(RegDistPerCount), 32'd5270718);
        write_reg(8'(RegAnglePerCount), 32'd715827883);
        write_reg(8'(RegVelocityScale), 32'd838861);
        write_reg(8'(RegInvWheelBase), 32'd218453);
        random_phase(NumRandom / 4);
        drain();

        $display("sent %0d requests over six register settings, %0d results checked",
                 items_sent, results_seen);
        $display("covered encoder wrap, saturated position and velocity, zero and full scales");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
